>>> hdl/round_robin_quantum_scheduler_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin scheduler
// Implication checks, sampled on the rising clock edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_TOP_MACROS_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define RRQS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rrqs: same-cycle check failed");

// next-cycle implication
`define RRQS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rrqs: next-cycle check failed");

`endif

>>> hdl/rrqs_pkg.sv
// ----------------------------------------------------------------------------
// rrqs_pkg
// Types and constants shared by the round-robin scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rrqs_pkg;

    // queue depth; pointer arithmetic wraps, so keep it a power of two
    localparam int MAX_TASKS = 16;
    localparam int TASK_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int ID_W   = 4;
    localparam int SVC_W  = 16;
    localparam int QNT_W  = 8;
    localparam int TICK_W = 32;
    localparam int CODE_W = 3;

    typedef enum logic {
        KIND_TICK   = 1'b0,
        KIND_ARRIVE = 1'b1
    } t_kind;

    typedef enum logic [CODE_W-1:0] {
        EV_SWITCH    = 3'd0,
        EV_STARTED   = 3'd1,
        EV_RESUMED   = 3'd2,
        EV_SLICE     = 3'd3,
        EV_FINISHED  = 3'd4,
        EV_PREEMPTED = 3'd5
    } t_evt_code;

    typedef struct packed {
        logic [CODE_W-1:0] event_code;
        logic [ID_W-1:0]   event_task;
        logic [SVC_W-1:0]  left_service;
        logic [QNT_W-1:0]  left_quantum;
        logic [TICK_W-1:0] tick_stamp;
        logic              last_event;
    } t_evt;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [TASK_W-1:0] push_id;
    } t_fifo_ctl;

    typedef struct packed {
        logic [TASK_W-1:0] head_id;
        logic [CNT_W-1:0]  count;
        logic              full;
        logic              empty;
    } t_fifo_sts;

    typedef struct packed {
        logic              svc_we;
        logic              st_we;
        logic              st_wval;
        logic [TASK_W-1:0] wr_addr;
        logic [SVC_W-1:0]  svc_wdata;
        logic [TASK_W-1:0] rd_addr;
    } t_tbl_ctl;

    typedef struct packed {
        logic [SVC_W-1:0] rd_svc;
        logic             rd_started;
    } t_tbl_sts;

    typedef struct packed {
        logic busy;
        logic run_valid;
    } t_ctl_sts;

endpackage

`default_nettype wire

>>> hdl/rrqs_ifs.sv
// ----------------------------------------------------------------------------
// rrqs channel interfaces
// Valid/ready channels for scheduler requests and event records.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrqs_in_if import rrqs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [ID_W-1:0]  task_id;
    logic [SVC_W-1:0] burst_len;

    modport source (output valid, kind, task_id, burst_len, input ready);
    modport sink   (input valid, kind, task_id, burst_len, output ready);
endinterface

interface rrqs_out_if import rrqs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] event_code;
    logic [ID_W-1:0]   event_task;
    logic [SVC_W-1:0]  left_service;
    logic [QNT_W-1:0]  left_quantum;
    logic [TICK_W-1:0] tick_stamp;
    logic              last_event;

    modport source (output valid, event_code, event_task, left_service, left_quantum,
                    tick_stamp, last_event, input ready);
    modport sink   (input valid, event_code, event_task, left_service, left_quantum,
                    tick_stamp, last_event, output ready);
endinterface

`default_nettype wire

>>> hdl/round_robin_quantum_scheduler_top.sv
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_top
// Round-robin time-slice scheduler: ready queue, task table, tick sequencer.
// ----------------------------------------------------------------------------
//   channel    dir   handshake      beat contents
//   i_req      in    valid/ready    kind, task_id, burst_len
//   o_evt      out   valid/ready    event_code .. last_event, one record per beat
//   i_cfg_*    in    write enable   time_quantum
//
// An arrival is handled in IDLE; a tick with nothing to do only advances the
// tick count, a plain charge walks CHG and DONE, a finish adds FIN, a dispatch
// adds DSP, SW and ST, a preempt with redispatch adds PRE, DSP, SW and ST. The
// sequencer walks one event step per cycle while the output register has room,
// with one shared decrement unit; the task table read is registered. Reset
// clears control state only; the table and queue need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "round_robin_quantum_scheduler_top_macros.svh"

module round_robin_quantum_scheduler_top import rrqs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    rrqs_in_if.sink         i_req,
    rrqs_out_if.source      o_evt
);

    t_fifo_ctl w_fctl;
    t_fifo_sts w_fsts;
    t_tbl_ctl  w_tctl;
    t_tbl_sts  w_tsts;
    t_ctl_sts  w_csts;
    logic      w_tick_work;

    rrqs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_fctl),
        .o_sts   (w_fsts)
    );

    rrqs_task_tbl u_tbl (
        .i_clk (i_clk),
        .i_ctl (w_tctl),
        .o_sts (w_tsts)
    );

    rrqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_evt       (o_evt),
        .i_fsts      (w_fsts),
        .o_fctl      (w_fctl),
        .i_tsts      (w_tsts),
        .o_tctl      (w_tctl),
        .o_csts      (w_csts)
    );

    // accepted tick that has a task to charge or dispatch
    assign w_tick_work = i_req.valid && i_req.ready && (i_req.kind == KIND_TICK)
                         && (w_csts.run_valid || !w_fsts.empty);

    `RRQS_ASSERT_IMP(a_fifo_bound, i_clk, i_rst_n, 1'b1, w_fsts.count <= CNT_W'(MAX_TASKS))
    `RRQS_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, w_fctl.pop, !w_fsts.empty && !w_fctl.push)
    `RRQS_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, w_tick_work, !i_req.ready && w_csts.busy)

endmodule

`default_nettype wire

>>> hdl/rrqs_fifo.sv
// ----------------------------------------------------------------------------
// rrqs_fifo
// Ready queue of task ids: push at tail, pop at head, never both at once.
// ----------------------------------------------------------------------------
`default_nettype none

module rrqs_fifo import rrqs_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_fifo_ctl i_ctl,
    output t_fifo_sts      o_sts
);

    logic [TASK_W-1:0] r_q [MAX_TASKS];
    logic [TASK_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [TASK_W-1:0] w_tail;
    logic              w_full;

    assign w_full = (r_count == CNT_W'(MAX_TASKS));
    assign w_tail = r_head + r_count[TASK_W-1:0];

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctl.push && !w_full) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop && r_count != '0) begin
            n_head  = r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !w_full) begin
            r_q[w_tail] <= i_ctl.push_id;
        end
    end

    assign o_sts.head_id = r_q[r_head];
    assign o_sts.count   = r_count;
    assign o_sts.full    = w_full;
    assign o_sts.empty   = (r_count == '0);

endmodule

`default_nettype wire

>>> hdl/rrqs_task_tbl.sv
// ----------------------------------------------------------------------------
// rrqs_task_tbl
// Per-task remaining service memory and started flags, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rrqs_task_tbl import rrqs_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_tbl_ctl i_ctl,
    output t_tbl_sts      o_sts
);

    logic [SVC_W-1:0]     r_svc_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_started;
    logic [SVC_W-1:0]     r_rd_svc;
    logic                 r_rd_started;

    // entries are only read for ids that were enqueued, hence written
    always_ff @(posedge i_clk) begin
        if (i_ctl.svc_we) begin
            r_svc_mem[i_ctl.wr_addr] <= i_ctl.svc_wdata;
        end
        if (i_ctl.st_we) begin
            r_started[i_ctl.wr_addr] <= i_ctl.st_wval;
        end
        r_rd_svc     <= r_svc_mem[i_ctl.rd_addr];
        r_rd_started <= r_started[i_ctl.rd_addr];
    end

    assign o_sts.rd_svc     = r_rd_svc;
    assign o_sts.rd_started = r_rd_started;

endmodule

`default_nettype wire

>>> hdl/rrqs_ctrl.sv
// ----------------------------------------------------------------------------
// rrqs_ctrl
// Tick sequencer and arrival handler: dispatch, charge, finish and preempt
// steps, their event records sent through a single output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrqs_ctrl import rrqs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    rrqs_in_if.sink         i_req,
    rrqs_out_if.source      o_evt,
    input  wire t_fifo_sts  i_fsts,
    output t_fifo_ctl       o_fctl,
    input  wire t_tbl_sts   i_tsts,
    output t_tbl_ctl        o_tctl,
    output t_ctl_sts        o_csts
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DSP  = 8'b0000_0010,
        S_SW   = 8'b0000_0100,
        S_ST   = 8'b0000_1000,
        S_CHG  = 8'b0001_0000,
        S_FIN  = 8'b0010_0000,
        S_PRE  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [QNT_W-1:0]  r_quantum;
    logic              r_run_valid, n_run_valid;
    logic [TASK_W-1:0] r_run_task, n_run_task;
    logic [SVC_W-1:0]  r_run_svc, n_run_svc;
    logic [QNT_W-1:0]  r_slice, n_slice;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic              r_second, n_second;
    t_evt              r_out, n_out;
    logic              r_ovalid, n_ovalid;

    logic              w_slot;
    logic              w_emit;
    logic [SVC_W-1:0]  w_svc_dec;
    logic [QNT_W-1:0]  w_slc_dec;
    logic              w_preempt;
    logic              w_in_fire;
    logic [TASK_W-1:0] w_in_id;

    // shared charge unit
    assign w_svc_dec = (r_run_svc != '0) ? r_run_svc - 1'b1 : r_run_svc;
    assign w_slc_dec = (r_quantum != '0 && r_slice != '0) ? r_slice - 1'b1 : r_slice;
    assign w_preempt = (r_quantum != '0) && (w_slc_dec == '0);

    assign w_slot    = !r_ovalid || o_evt.ready;
    assign w_in_fire = i_req.valid && (r_state == S_IDLE);
    assign w_in_id   = TASK_W'(i_req.task_id);

    always_comb begin
        n_state     = r_state;
        n_run_valid = r_run_valid;
        n_run_task  = r_run_task;
        n_run_svc   = r_run_svc;
        n_slice     = r_slice;
        n_tick      = r_tick;
        n_second    = r_second;
        n_out       = r_out;
        w_emit      = 1'b0;

        o_fctl.push    = 1'b0;
        o_fctl.pop     = 1'b0;
        o_fctl.push_id = w_in_id;

        o_tctl.svc_we    = 1'b0;
        o_tctl.st_we     = 1'b0;
        o_tctl.st_wval   = 1'b0;
        o_tctl.wr_addr   = r_run_task;
        o_tctl.svc_wdata = w_svc_dec;
        // hold the dispatched task's entry while switch/started records stall
        o_tctl.rd_addr   = (r_state == S_DSP) ? i_fsts.head_id : r_run_task;

        n_out.event_task   = ID_W'(r_run_task);
        n_out.left_service = r_run_svc;
        n_out.left_quantum = r_slice;
        n_out.tick_stamp   = r_tick;

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_req.kind == KIND_ARRIVE) begin
                        if (!i_fsts.full) begin
                            o_tctl.svc_we    = 1'b1;
                            o_tctl.st_we     = 1'b1;
                            o_tctl.st_wval   = 1'b0;
                            o_tctl.wr_addr   = w_in_id;
                            o_tctl.svc_wdata = i_req.burst_len;
                            o_fctl.push      = 1'b1;
                            // keep the cached copy coherent on a re-arrival
                            if (r_run_valid && r_run_task == w_in_id) begin
                                n_run_svc = i_req.burst_len;
                            end
                        end
                    end else if (r_run_valid) begin
                        n_state = S_CHG;
                    end else if (!i_fsts.empty) begin
                        n_second = 1'b0;
                        n_state  = S_DSP;
                    end else begin
                        n_tick = r_tick + 1'b1;
                    end
                end
            end
            S_DSP: begin
                o_fctl.pop  = 1'b1;
                n_run_task  = i_fsts.head_id;
                n_run_valid = 1'b1;
                n_slice     = r_quantum;
                n_state     = S_SW;
            end
            S_SW: begin
                if (w_slot) begin
                    w_emit             = 1'b1;
                    n_out.event_code   = EV_SWITCH;
                    n_out.left_service = i_tsts.rd_svc;
                    n_out.last_event   = 1'b0;
                    n_run_svc          = i_tsts.rd_svc;
                    n_state            = S_ST;
                end
            end
            S_ST: begin
                if (w_slot) begin
                    w_emit           = 1'b1;
                    n_out.event_code = i_tsts.rd_started ? EV_RESUMED : EV_STARTED;
                    n_out.last_event = r_second;
                    o_tctl.st_we     = 1'b1;
                    o_tctl.st_wval   = 1'b1;
                    n_state          = r_second ? S_DONE : S_CHG;
                end
            end
            S_CHG: begin
                if (w_slot) begin
                    w_emit             = 1'b1;
                    n_out.event_code   = EV_SLICE;
                    n_out.left_service = w_svc_dec;
                    n_out.left_quantum = w_slc_dec;
                    n_out.last_event   = (w_svc_dec != '0) && !w_preempt;
                    o_tctl.svc_we      = 1'b1;
                    n_run_svc          = w_svc_dec;
                    n_slice            = w_slc_dec;
                    if (w_svc_dec == '0) begin
                        n_state = S_FIN;
                    end else if (w_preempt) begin
                        n_state = S_PRE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FIN: begin
                if (w_slot) begin
                    w_emit           = 1'b1;
                    n_out.event_code = EV_FINISHED;
                    n_out.last_event = 1'b1;
                    n_run_valid      = 1'b0;
                    n_state          = S_DONE;
                end
            end
            S_PRE: begin
                // the queue is never empty after this, so a dispatch always follows
                if (w_slot) begin
                    w_emit           = 1'b1;
                    n_out.event_code = EV_PREEMPTED;
                    n_out.last_event = 1'b0;
                    o_fctl.push      = 1'b1;
                    o_fctl.push_id   = r_run_task;
                    n_run_valid      = 1'b0;
                    n_second         = 1'b1;
                    n_state          = S_DSP;
                end
            end
            S_DONE: begin
                n_tick  = r_tick + 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_emit) begin
            n_ovalid = 1'b1;
        end else if (o_evt.ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_quantum   <= QNT_W'(4);
            r_run_valid <= 1'b0;
            r_run_task  <= '0;
            r_run_svc   <= '0;
            r_slice     <= '0;
            r_tick      <= '0;
            r_second    <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run_valid <= n_run_valid;
            r_run_task  <= n_run_task;
            r_run_svc   <= n_run_svc;
            r_slice     <= n_slice;
            r_tick      <= n_tick;
            r_second    <= n_second;
            r_ovalid    <= n_ovalid;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
        end
    end

    // payload only loads on a new record, so a waiting beat stays put
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_evt.valid        = r_ovalid;
    assign o_evt.event_code   = r_out.event_code;
    assign o_evt.event_task   = r_out.event_task;
    assign o_evt.left_service = r_out.left_service;
    assign o_evt.left_quantum = r_out.left_quantum;
    assign o_evt.tick_stamp   = r_out.tick_stamp;
    assign o_evt.last_event   = r_out.last_event;

    assign o_csts.busy      = (r_state != S_IDLE);
    assign o_csts.run_valid = r_run_valid;

endmodule

`default_nettype wire
